// ===== sv/dqp_pkg.sv =====
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types, codes and helpers for the DNS question parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_LEN    = 3'd2,
    PH_CHARS  = 3'd3,
    PH_QTH    = 3'd4,
    PH_QTL    = 3'd5,
    PH_QCLASS = 3'd6,
    PH_IDLE   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME      = 2'd0,
    KIND_QDONE     = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_RESPONSE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    QC_UNKNOWN = 4'd0,
    QC_A       = 4'd1,
    QC_NS      = 4'd2,
    QC_CNAME   = 4'd3,
    QC_SOA     = 4'd4,
    QC_PTR     = 4'd5,
    QC_MX      = 4'd6,
    QC_TXT     = 4'd7,
    QC_RP      = 4'd8,
    QC_AAAA    = 4'd9,
    QC_LOC     = 4'd10,
    QC_SRV     = 4'd11,
    QC_SSHFP   = 4'd12,
    QC_ANY     = 4'd13
  } qclass_e;

  localparam logic [3:0] HdrQrOffset   = 4'd2;
  localparam logic [3:0] HdrQdHiOffset = 4'd4;
  localparam logic [3:0] HdrQdLoOffset = 4'd5;
  localparam logic [3:0] HdrLastOffset = 4'd11;

  // one queued result word
  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;      // name byte in [7:0] or QTYPE
    logic        label_end;
    logic        last_q;
    logic [15:0] q_index;
  } entry_t;

  function automatic qclass_e map_qtype(input logic [15:0] t);
    qclass_e c;
    case (t)
      16'd1:   c = QC_A;
      16'd2:   c = QC_NS;
      16'd5:   c = QC_CNAME;
      16'd6:   c = QC_SOA;
      16'd12:  c = QC_PTR;
      16'd15:  c = QC_MX;
      16'd16:  c = QC_TXT;
      16'd17:  c = QC_RP;
      16'd28:  c = QC_AAAA;
      16'd29:  c = QC_LOC;
      16'd33:  c = QC_SRV;
      16'd44:  c = QC_SSHFP;
      16'd255: c = QC_ANY;
      default: c = QC_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b > 8'd32) && !b[7];
  endfunction

endpackage

// ===== sv/dqp_front.sv =====
// ----------------------------------------------------------------------------
// dqp_front
// Byte parser: walks header, labels and QTYPE, emits result words.
// ----------------------------------------------------------------------------
module dqp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      msg_byte_i,
  input  logic            start_of_message_i,
  output logic            push_o,
  output dqp_pkg::entry_t entry_o
);

  dqp_pkg::phase_e phase_q, phase_d;
  logic [3:0]      offset_q, offset_d;
  logic [15:0]     qleft_q, qleft_d;
  logic [7:0]      lleft_q, lleft_d;
  logic [7:0]      qth_q, qth_d;
  logic [15:0]     qcount_q, qcount_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dqp_pkg::PH_WAIT;
      offset_q <= '0;
      qleft_q  <= '0;
      lleft_q  <= '0;
      qth_q    <= '0;
      qcount_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      qleft_q  <= qleft_d;
      lleft_q  <= lleft_d;
      qth_q    <= qth_d;
      qcount_q <= qcount_d;
    end
  end

  always_comb begin
    dqp_pkg::phase_e ph;
    logic [15:0] qt;
    ph       = start_of_message_i ? dqp_pkg::PH_HEADER : phase_q;
    offset_d = start_of_message_i ? 4'd0  : offset_q;
    qleft_d  = start_of_message_i ? 16'd0 : qleft_q;
    lleft_d  = start_of_message_i ? 8'd0  : lleft_q;
    qth_d    = start_of_message_i ? 8'd0  : qth_q;
    qcount_d = start_of_message_i ? 16'd0 : qcount_q;
    phase_d  = ph;
    qt       = {qth_d, msg_byte_i};
    push_o   = 1'b0;
    entry_o  = '0;

    case (ph)
      dqp_pkg::PH_HEADER: begin
        if (offset_d == dqp_pkg::HdrQrOffset && msg_byte_i[7]) begin
          phase_d       = dqp_pkg::PH_IDLE;
          push_o        = 1'b1;
          entry_o.kind  = dqp_pkg::KIND_RESPONSE;
        end else begin
          if (offset_d == dqp_pkg::HdrQdHiOffset) begin
            qleft_d = {msg_byte_i, 8'd0};
          end else if (offset_d == dqp_pkg::HdrQdLoOffset) begin
            qleft_d = {qleft_d[15:8], msg_byte_i};
          end
          if (offset_d >= dqp_pkg::HdrLastOffset) begin
            offset_d = 4'd0;
            phase_d  = (qleft_d == 16'd0) ? dqp_pkg::PH_IDLE : dqp_pkg::PH_LEN;
          end else begin
            offset_d = offset_d + 4'd1;
          end
        end
      end
      dqp_pkg::PH_LEN: begin
        if (msg_byte_i == 8'd0) begin
          phase_d = dqp_pkg::PH_QTH;
        end else begin
          lleft_d = msg_byte_i;
          phase_d = dqp_pkg::PH_CHARS;
        end
      end
      dqp_pkg::PH_CHARS: begin
        push_o          = 1'b1;
        entry_o.q_index = qcount_d;
        if (msg_byte_i == 8'd0) begin
          entry_o.kind = dqp_pkg::KIND_MALFORMED;
          lleft_d      = 8'd0;
          phase_d      = dqp_pkg::PH_QTH;
        end else begin
          entry_o.kind      = dqp_pkg::KIND_NAME;
          entry_o.value     = {8'd0, msg_byte_i};
          entry_o.label_end = (lleft_d <= 8'd1);
          if (lleft_d <= 8'd1) begin
            lleft_d = 8'd0;
            phase_d = dqp_pkg::PH_LEN;
          end else begin
            lleft_d = lleft_d - 8'd1;
          end
        end
      end
      dqp_pkg::PH_QTH: begin
        qth_d   = msg_byte_i;
        phase_d = dqp_pkg::PH_QTL;
      end
      dqp_pkg::PH_QTL: begin
        push_o          = 1'b1;
        entry_o.kind    = dqp_pkg::KIND_QDONE;
        entry_o.value   = qt;
        entry_o.q_index = qcount_d;
        entry_o.last_q  = (qleft_d == 16'd1);
        qleft_d         = qleft_d - 16'd1;
        qcount_d        = qcount_d + 16'd1;
        offset_d        = 4'd0;
        phase_d         = dqp_pkg::PH_QCLASS;
      end
      dqp_pkg::PH_QCLASS: begin
        if (offset_d == 4'd0) begin
          offset_d = 4'd1;
        end else begin
          offset_d = 4'd0;
          phase_d  = (qleft_d == 16'd0) ? dqp_pkg::PH_IDLE : dqp_pkg::PH_LEN;
        end
      end
      default: begin
        phase_d = ph;
      end
    endcase
  end

endmodule

// ===== sv/dqp_queue.sv =====
// ----------------------------------------------------------------------------
// dqp_queue
// Short FIFO of result words between parser and output stage.
// ----------------------------------------------------------------------------
module dqp_queue #(
  parameter int unsigned Depth = dqp_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dqp_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output dqp_pkg::entry_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dqp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dqp_back.sv =====
// ----------------------------------------------------------------------------
// dqp_back
// Output stage: decodes a queued word into result fields and holds them.
// ----------------------------------------------------------------------------
module dqp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dqp_pkg::entry_t entry_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      name_byte_o,
  output logic            printable_o,
  output logic            label_end_o,
  output logic [15:0]     qtype_raw_o,
  output logic [3:0]      qtype_class_o,
  output logic [15:0]     question_index_o,
  output logic            last_question_o
);

  logic valid_q;
  logic is_name, is_qdone;

  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign is_name     = (entry_i.kind == dqp_pkg::KIND_NAME);
  assign is_qdone    = (entry_i.kind == dqp_pkg::KIND_QDONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_o           <= entry_i.kind;
      name_byte_o      <= is_name ? entry_i.value[7:0] : 8'd0;
      printable_o      <= is_name && dqp_pkg::is_printable(entry_i.value[7:0]);
      label_end_o      <= is_name && entry_i.label_end;
      qtype_raw_o      <= is_qdone ? entry_i.value : 16'd0;
      qtype_class_o    <= is_qdone ? dqp_pkg::map_qtype(entry_i.value)
                                   : dqp_pkg::QC_UNKNOWN;
      question_index_o <= entry_i.q_index;
      last_question_o  <= is_qdone && entry_i.last_q;
    end
  end

endmodule

// ===== sv/dns_question_parser_core.sv =====
// ----------------------------------------------------------------------------
// dns_question_parser_core
// DNS question section parser, one message byte per word.
// ----------------------------------------------------------------------------
// Takes one message byte per clock cycle with no gaps needed, as long as the
// result queue has room, and emits at most one result word per input byte:
// name characters, question done with the QTYPE class, malformed label, or
// response ignored. The rate is set by the byte parser, whose state is
// updated at each accepted byte. A result word is written to the result
// queue when its byte is accepted and then moves to the output register,
// from which it can be taken. The queue of QueueDepth words lets input
// continue while the output side stalls.
module dns_question_parser_core #(
  parameter int unsigned QueueDepth = dqp_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        start_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_byte_o,
  output logic        printable_o,
  output logic        label_end_o,
  output logic [15:0] qtype_raw_o,
  output logic [3:0]  qtype_class_o,
  output logic [15:0] question_index_o,
  output logic        last_question_o
);

  logic            accept, push, pop, full, empty;
  dqp_pkg::entry_t push_entry, head_entry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  dqp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .msg_byte_i         (msg_byte_i),
    .start_of_message_i (start_of_message_i),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  dqp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && accept),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  dqp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_i          (head_entry),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .name_byte_o      (name_byte_o),
    .printable_o      (printable_o),
    .label_end_o      (label_end_o),
    .qtype_raw_o      (qtype_raw_o),
    .qtype_class_o    (qtype_class_o),
    .question_index_o (question_index_o),
    .last_question_o  (last_question_o)
  );

endmodule

// ===== bench/dqp_checker.sv =====
// ----------------------------------------------------------------------------
// dqp_checker
// Watches both channels of the DNS question parser and checks every result.
// ----------------------------------------------------------------------------
// Each accepted message byte runs through a cycle-free model of the parser.
// The model keeps its own header, label and question state and queues the
// result word that the byte should produce. Each accepted result word is
// compared with the oldest queued one. A result with nothing queued counts
// as a failure, and so does a mismatch. The first ten are printed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dqp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  msg_byte_i,
  input  logic        start_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  name_byte_i,
  input  logic        printable_i,
  input  logic        label_end_i,
  input  logic [15:0] qtype_raw_i,
  input  logic [3:0]  qtype_class_i,
  input  logic [15:0] question_index_i,
  input  logic        last_question_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          results_o,
  output int          qdone_o,
  output int          malformed_o,
  output int          response_o
);

  localparam logic [7:0] PrintMin   = 8'd32;
  localparam logic [7:0] PrintLimit = 8'd128;
  localparam int unsigned MaxReports = 10;

  // known QTYPE values, entry i maps to class i + 1
  localparam logic [12:0][15:0] QtypeCodes = {
    16'd255, 16'd44, 16'd33, 16'd29, 16'd28, 16'd17, 16'd16,
    16'd15, 16'd12, 16'd6, 16'd5, 16'd2, 16'd1
  };

  typedef struct packed {
    dqp_pkg::kind_e   kind;
    logic [7:0]       name_byte;
    logic             printable;
    logic             label_end;
    logic [15:0]      qtype_raw;
    dqp_pkg::qclass_e qtype_class;
    logic [15:0]      question_index;
    logic             last_question;
  } dns_event_t;

  dns_event_t  dns_events_q[$];

  dqp_pkg::phase_e ph;
  logic [3:0]  offs;
  logic [15:0] q_left;
  logic [7:0]  lbl_left;
  logic [7:0]  qt_hi;
  logic [15:0] q_idx;

  function automatic dqp_pkg::qclass_e classify_qtype(input logic [15:0] t);
    dqp_pkg::qclass_e c;
    c = dqp_pkg::QC_UNKNOWN;
    for (int i = 0; i < 13; i++) begin
      if (QtypeCodes[i] == t) c = dqp_pkg::qclass_e'(i + 1);
    end
    return c;
  endfunction

  task parse_msg_byte(input logic [7:0] b, input logic som);
    dns_event_t ev;
    logic [15:0] qt;
    ev = '0;
    if (som) begin
      ph       = dqp_pkg::PH_HEADER;
      offs     = '0;
      q_left   = '0;
      lbl_left = '0;
      qt_hi    = '0;
      q_idx    = '0;
    end
    case (ph)
      dqp_pkg::PH_HEADER: begin
        if (offs == dqp_pkg::HdrQrOffset && b[7]) begin
          ph      = dqp_pkg::PH_IDLE;
          ev.kind = dqp_pkg::KIND_RESPONSE;
          dns_events_q.push_back(ev);
        end else begin
          if (offs == dqp_pkg::HdrQdHiOffset) q_left = {b, 8'h00};
          else if (offs == dqp_pkg::HdrQdLoOffset) q_left = q_left | {8'h00, b};
          if (offs >= dqp_pkg::HdrLastOffset) begin
            offs = '0;
            ph   = (q_left == '0) ? dqp_pkg::PH_IDLE : dqp_pkg::PH_LEN;
          end else begin
            offs = offs + 4'd1;
          end
        end
      end
      dqp_pkg::PH_LEN: begin
        if (b == '0) begin
          ph = dqp_pkg::PH_QTH;
        end else begin
          lbl_left = b;
          ph       = dqp_pkg::PH_CHARS;
        end
      end
      dqp_pkg::PH_CHARS: begin
        ev.question_index = q_idx;
        if (b == '0) begin
          ev.kind  = dqp_pkg::KIND_MALFORMED;
          lbl_left = '0;
          ph       = dqp_pkg::PH_QTH;
        end else begin
          ev.kind      = dqp_pkg::KIND_NAME;
          ev.name_byte = b;
          ev.printable = (b > PrintMin) && (b < PrintLimit);
          ev.label_end = (lbl_left <= 8'd1);
          if (lbl_left <= 8'd1) begin
            lbl_left = '0;
            ph       = dqp_pkg::PH_LEN;
          end else begin
            lbl_left = lbl_left - 8'd1;
          end
        end
        dns_events_q.push_back(ev);
      end
      dqp_pkg::PH_QTH: begin
        qt_hi = b;
        ph    = dqp_pkg::PH_QTL;
      end
      dqp_pkg::PH_QTL: begin
        qt                = {qt_hi, b};
        ev.kind           = dqp_pkg::KIND_QDONE;
        ev.qtype_raw      = qt;
        ev.qtype_class    = classify_qtype(qt);
        ev.question_index = q_idx;
        ev.last_question  = (q_left == 16'd1);
        q_left            = q_left - 16'd1;
        q_idx             = q_idx + 16'd1;
        offs              = '0;
        ph                = dqp_pkg::PH_QCLASS;
        dns_events_q.push_back(ev);
      end
      dqp_pkg::PH_QCLASS: begin
        if (offs == '0) begin
          offs = 4'd1;
        end else begin
          offs = '0;
          ph   = (q_left == '0) ? dqp_pkg::PH_IDLE : dqp_pkg::PH_LEN;
        end
      end
      default: ;
    endcase
  endtask

  task report_result(input dns_event_t got);
    dns_event_t want;
    if (dns_events_q.size() == 0) begin
      fail_cnt_o++;
      if (fail_cnt_o <= MaxReports)
        $display("%0t: unexpected word kind=%0d byte=%02h qt=%04h idx=%0d", $time,
                 got.kind, got.name_byte, got.qtype_raw, got.question_index);
    end else begin
      want = dns_events_q.pop_front();
      if (got !== want) begin
        fail_cnt_o++;
        if (fail_cnt_o <= MaxReports) begin
          $display("%0t: mismatch on result %0d", $time, results_o);
          $display("  exp kind=%0d byte=%02h prt=%b end=%b qt=%04h qc=%0d idx=%0d last=%b",
                   want.kind, want.name_byte, want.printable, want.label_end,
                   want.qtype_raw, want.qtype_class, want.question_index,
                   want.last_question);
          $display("  got kind=%0d byte=%02h prt=%b end=%b qt=%04h qc=%0d idx=%0d last=%b",
                   got.kind, got.name_byte, got.printable, got.label_end,
                   got.qtype_raw, got.qtype_class, got.question_index,
                   got.last_question);
        end
      end
    end
    results_o++;
    case (got.kind)
      dqp_pkg::KIND_QDONE:     qdone_o++;
      dqp_pkg::KIND_MALFORMED: malformed_o++;
      dqp_pkg::KIND_RESPONSE:  response_o++;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dns_event_t got;
    if (!rst_ni) begin
      ph       = dqp_pkg::PH_WAIT;
      offs     = '0;
      q_left   = '0;
      lbl_left = '0;
      qt_hi    = '0;
      q_idx    = '0;
      dns_events_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
      results_o   = 0;
      qdone_o     = 0;
      malformed_o = 0;
      response_o  = 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_msg_byte(msg_byte_i, start_of_message_i);
      if (out_valid_i && out_ready_i) begin
        got.kind           = dqp_pkg::kind_e'(kind_i);
        got.name_byte      = name_byte_i;
        got.printable      = printable_i;
        got.label_end      = label_end_i;
        got.qtype_raw      = qtype_raw_i;
        got.qtype_class    = dqp_pkg::qclass_e'(qtype_class_i);
        got.question_index = question_index_i;
        got.last_question  = last_question_i;
        report_result(got);
      end
      pending_o = dns_events_q.size();
    end
  end

endmodule

// ===== bench/tb_dns_question_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_dns_question_parser_core
// Byte-stream test of the DNS question parser core.
// ----------------------------------------------------------------------------
// Feeds DNS messages one byte per word: stray bytes before any start, queries
// and responses, zero and maximal question counts, short and long labels,
// zero bytes inside labels, and messages cut short by a new start. Both
// channels pause in random bursts, except in the closing stretch. The
// checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dns_question_parser_core;

  localparam int TotalBytes = 700;
  localparam int QuietFrom  = 560;
  localparam int CycleLimit = 300000;
  localparam int DrainWait  = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  msg_byte_i;
  logic        start_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  name_byte_o;
  logic        printable_o;
  logic        label_end_o;
  logic [15:0] qtype_raw_o;
  logic [3:0]  qtype_class_o;
  logic [15:0] question_index_o;
  logic        last_question_o;

  int fail_cnt, pending_cnt, result_cnt, qdone_cnt, malformed_cnt, response_cnt;
  int byte_cnt, msg_cnt, cut_cnt, cycle_cnt;
  int in_gap_pct, out_stall_pct, stall_left;

  dns_question_parser_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .msg_byte_i,
    .start_of_message_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .name_byte_o,
    .printable_o,
    .label_end_o,
    .qtype_raw_o,
    .qtype_class_o,
    .question_index_o,
    .last_question_o
  );

  dqp_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i         (in_ready_o),
    .msg_byte_i,
    .start_of_message_i,
    .out_valid_i        (out_valid_o),
    .out_ready_i,
    .kind_i             (kind_o),
    .name_byte_i        (name_byte_o),
    .printable_i        (printable_o),
    .label_end_i        (label_end_o),
    .qtype_raw_i        (qtype_raw_o),
    .qtype_class_i      (qtype_class_o),
    .question_index_i   (question_index_o),
    .last_question_i    (last_question_o),
    .fail_cnt_o         (fail_cnt),
    .pending_o          (pending_cnt),
    .results_o          (result_cnt),
    .qdone_o            (qdone_cnt),
    .malformed_o        (malformed_cnt),
    .response_o         (response_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial stall_left = 0;

  // output side back-pressure, in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[dns_question_parser_core] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic som);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    msg_byte_i         <= b;
    start_of_message_i <= som;
    do @(posedge clk_i); while (!in_ready_o);
    byte_cnt++;
  endtask

  // builds one message and sends it, or only its first cut bytes
  task automatic send_message(input bit resp, input logic [15:0] qd, input int n_q,
                              input int cut);
    logic [7:0]  m[$];
    logic [15:0] qt;
    int          len, n_send, r;
    m.push_back(8'($urandom));
    m.push_back(8'($urandom));
    m.push_back({resp, 7'($urandom)});
    m.push_back(8'($urandom));
    m.push_back(qd[15:8]);
    m.push_back(qd[7:0]);
    repeat (6) m.push_back(8'($urandom));
    repeat (n_q) begin
      repeat ($urandom_range(0, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 63);
        else if (r < 99) len = $urandom_range(64, 90);
        else len = 255;
        m.push_back(8'(len));
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 3) m.push_back(8'h00);
          else if (r < 73) m.push_back(8'($urandom_range(33, 126)));
          else m.push_back(8'($urandom));
        end
      end
      m.push_back(8'h00);
      r = $urandom_range(0, 99);
      if (r < 50) qt = 16'($urandom_range(0, 48));
      else if (r < 60) qt = 16'd255;
      else if (r < 65) qt = 16'hffff;
      else qt = 16'($urandom);
      m.push_back(qt[15:8]);
      m.push_back(qt[7:0]);
      if ($urandom_range(0, 3) == 0) begin
        m.push_back(8'($urandom));
        m.push_back(8'($urandom));
      end else begin
        m.push_back(8'h00);
        m.push_back(8'h01);
      end
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) m.push_back(8'($urandom));
    n_send = (cut > 0 && cut < m.size()) ? cut : m.size();
    for (int i = 0; i < n_send; i++) send_byte(m[i], i == 0);
    msg_cnt++;
  endtask

  initial begin
    logic [7:0]  dir_q[$];
    logic [15:0] qd;
    int          n_q, cut, r;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    msg_byte_i         = '0;
    start_of_message_i = 1'b0;
    in_gap_pct         = 0;
    out_stall_pct      = 0;
    byte_cnt           = 0;
    msg_cnt            = 0;
    cut_cnt            = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stray bytes before any start, then a response cut after its first flags byte
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_message(1'b1, 16'h0001, 1, 3);
    // one query: QR clear, single label with printable edges, QTYPE ANY
    dir_q = '{8'h00, 8'h00, 8'h7f, 8'hff, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff,
              8'hff, 8'hff, 8'h03, 8'h20, 8'h21, 8'h80, 8'h00, 8'h00, 8'hff,
              8'h00, 8'h01};
    foreach (dir_q[i]) send_byte(dir_q[i], i == 0);
    msg_cnt++;

    while (byte_cnt < TotalBytes) begin
      if (byte_cnt >= QuietFrom) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else if (msg_cnt % 4 == 0) begin
        r             = $urandom_range(0, 2);
        in_gap_pct    = (r == 0) ? 0 : (r == 1) ? 15 : 40;
        r             = $urandom_range(0, 2);
        out_stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
      end
      n_q = $urandom_range(1, 3);
      r   = $urandom_range(0, 99);
      if (r < 60) qd = 16'(n_q);
      else if (r < 70) qd = 16'h0000;
      else if (r < 80) qd = 16'hffff;
      else qd = 16'($urandom_range(1, 4));
      cut = 0;
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, 30);
        cut_cnt++;
      end
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      send_message($urandom_range(0, 99) < 8, qd, n_q, cut);
    end
    in_valid_i <= 1'b0;

    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d message bytes in %0d messages, %0d of them cut short by a restart.",
             byte_cnt, msg_cnt, cut_cnt);
    $display("Checked %0d result words: %0d questions, %0d malformed labels, %0d responses.",
             result_cnt, qdone_cnt, malformed_cnt, response_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[dns_question_parser_core] OK");
    end else begin
      $display("[dns_question_parser_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dqp_pkg.sv
sv/dqp_front.sv
sv/dqp_queue.sv
sv/dqp_back.sv
sv/dns_question_parser_core.sv
bench/dqp_checker.sv
bench/tb_dns_question_parser_core.sv
